FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/sdpfa_pkg.sv
// ----------------------------------------------------------------------------
// sdpfa_pkg
// Constants and types for the soft-disk pair force accumulator.
// ----------------------------------------------------------------------------
package sdpfa_pkg;

    localparam int POS_FRAC_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = 1'b1;

    localparam logic [8:0]  BOX_RESET   = 9'd64;
    localparam logic [23:0] STIFF_RESET = 24'd65536;

    localparam int S_DATA_W = 144;
    localparam int M_DATA_W = 104;

    // command to the iterative root/divide unit
    typedef struct packed {
        logic start;
        logic is_sqrt;
    } iu_cmd_t;

    // saturate a 33-bit sum to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -33'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: design/sdpfa_iter_unit.sv
// ----------------------------------------------------------------------------
// sdpfa_iter_unit
// Shared compare-subtract unit: bit-serial integer square root or
// restoring division, one result bit per cycle; done is registered and
// rises together with the last result bit.
// ----------------------------------------------------------------------------
module sdpfa_iter_unit #(
    parameter int FRAC = sdpfa_pkg::POS_FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sdpfa_pkg::iu_cmd_t     cmd,
    input  logic [2*FRAC+1:0]      rad,
    input  logic [FRAC:0]          num,
    input  logic [FRAC:0]          den,
    output logic                   done,
    output logic [FRAC:0]          res
);
    import sdpfa_pkg::*;

    localparam int N  = FRAC + 1;
    localparam int RW = FRAC + 3;
    localparam int CW = $clog2(N + 1);

    logic          active_reg, active_next;
    logic          done_reg, done_next;
    logic          sqrt_reg, sqrt_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [N-1:0]  root_reg, root_next;
    logic [2*N-1:0] src_reg, src_next;
    logic [N-1:0]  den_reg, den_next;

    logic [RW-1:0] rem2, op_a, op_b, diff, keep;
    logic          ge;

    always_comb begin
        rem2 = {rem_reg[RW-3:0], src_reg[2*N-1:2*N-2]};
        op_a = sqrt_reg ? rem2 : rem_reg;
        op_b = sqrt_reg ? {root_reg, 2'b01} : RW'(den_reg);
        ge   = (op_a >= op_b);
        diff = op_a - op_b;
        keep = ge ? diff : op_a;
    end

    always_comb begin
        active_next = active_reg;
        done_next   = 1'b0;
        sqrt_next   = sqrt_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        src_next    = src_reg;
        den_next    = den_reg;
        if (cmd.start) begin
            active_next = 1'b1;
            sqrt_next   = cmd.is_sqrt;
            cnt_next    = '0;
            rem_next    = cmd.is_sqrt ? '0 : RW'(num);
            root_next   = '0;
            src_next    = rad;
            den_next    = den;
        end else if (active_reg) begin
            root_next = {root_reg[N-2:0], ge};
            src_next  = {src_reg[2*N-3:0], 2'b00};
            rem_next  = sqrt_reg ? keep : {keep[RW-2:0], 1'b0};
            cnt_next  = cnt_reg + CW'(1);
            if (cnt_reg == CW'(N - 1)) begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
        sqrt_reg <= sqrt_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        src_reg  <= src_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign res  = root_reg;

endmodule

FILE: design/soft_disk_pair_force_accumulator.sv
// ----------------------------------------------------------------------------
// soft_disk_pair_force_accumulator
// Harmonic soft-disk pair repulsion with minimum-image wrap, force
// accumulation and a torque from the summed force on the last pair.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one (self, other) pair per transfer; s_tuser marks the first
//   pair of a run (clears the force sums), s_tlast the last (emits a result).
//   m_* carries one result per run: force_x, force_y and torque_out.
//   cfg_we/cfg_idx/cfg_data write box_size (0) and stiffness (1); write only
//   while the block is idle.
// Processing:
//   A pair whose wrapped separation lies outside the unit square skips the
//   distance check; one inside it but beyond unit distance, or at zero
//   distance, skips the force. One in range runs one square root and two
//   divisions through the single shared compare-subtract unit. A last pair
//   adds the torque, done on the same shared multiplier. s_tready is high
//   only between pairs.
// Reset:
//   aresetn (synchronous, low) zeroes the sums, restores box_size 64 and
//   stiffness 1.0, and drops m_tvalid.
// Stall:
//   A result waits in the output register; the next pair is still taken and
//   processed, and only its own result holds until the previous one leaves.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module soft_disk_pair_force_accumulator #(
    parameter int POS_FRAC_BITS = sdpfa_pkg::POS_FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [sdpfa_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [sdpfa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // self_x, self_y, other_x, other_y, center_x, center_y (24 bit each)
    input  logic [sdpfa_pkg::S_DATA_W-1:0]      s_tdata,
    // first_pair
    input  logic                                s_tuser,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // force_x (32), force_y (32), torque_out (40)
    output logic [sdpfa_pkg::M_DATA_W-1:0]      m_tdata
);
    import sdpfa_pkg::*;

    localparam int F  = POS_FRAC_BITS;
    localparam int N  = F + 1;
    localparam int WW = ((F + 9 > 25) ? F + 9 : 25) + 2;
    localparam int MB = (F + 2 > 25) ? F + 2 : 25;
    localparam int PW = 33 + MB;
    localparam int DL = 2 * F + 2;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_WRAP = 5'd1;
    localparam logic [4:0] S_SQX  = 5'd2;
    localparam logic [4:0] S_SQY  = 5'd3;
    localparam logic [4:0] S_CHK  = 5'd4;
    localparam logic [4:0] S_SQRT = 5'd5;
    localparam logic [4:0] S_MAG  = 5'd6;
    localparam logic [4:0] S_DIVX = 5'd7;
    localparam logic [4:0] S_MULX = 5'd8;
    localparam logic [4:0] S_ADDX = 5'd9;
    localparam logic [4:0] S_DIVY = 5'd10;
    localparam logic [4:0] S_MULY = 5'd11;
    localparam logic [4:0] S_ADDY = 5'd12;
    localparam logic [4:0] S_LAST = 5'd13;
    localparam logic [4:0] S_T1   = 5'd14;
    localparam logic [4:0] S_T2   = 5'd15;
    localparam logic [4:0] S_T3   = 5'd16;
    localparam logic [4:0] S_T4   = 5'd17;

    logic [4:0]  state_reg, state_next;
    logic [8:0]  box_reg;
    logic [23:0] stiff_reg;

    logic signed [23:0] sx_reg, sy_reg, ox_reg, oy_reg;
    logic signed [24:0] rx_reg, ry_reg;
    logic               last_reg;
    logic signed [WW-1:0] dx_reg, dy_reg;
    logic signed [PW-1:0] prod_reg, acc_reg;
    logic [N-1:0]       d_reg;
    logic [23:0]        mag_reg;
    logic signed [31:0] sum_x_reg, sum_y_reg;
    logic               mvalid_reg;
    logic [M_DATA_W-1:0] mdata_reg;

    logic s_acc, out_free;
    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;

    // minimum-image wrap, applied once
    function automatic logic signed [WW-1:0] wrap_f(input logic signed [WW-1:0] d,
                                                    input logic signed [WW-1:0] len,
                                                    input logic signed [WW-1:0] half);
        logic signed [WW-1:0] r;
        if (d > half) begin
            r = d - len;
        end else if (d < -half) begin
            r = d + len;
        end else begin
            r = d;
        end
        return r;
    endfunction

    logic [8:0]           box_c;
    logic signed [WW-1:0] len_w, half_w, one_w, wx, wy;
    logic                 near;
    always_comb begin
        if (box_reg < 9'd2) begin
            box_c = 9'd2;
        end else if (box_reg > 9'd256) begin
            box_c = 9'd256;
        end else begin
            box_c = box_reg;
        end
        len_w  = WW'(box_c) << F;
        half_w = WW'(box_c) << (F - 1);
        one_w  = WW'(1) << F;
        wx = wrap_f(WW'(sx_reg) - WW'(ox_reg), len_w, half_w);
        wy = wrap_f(WW'(sy_reg) - WW'(oy_reg), len_w, half_w);
        near = (wx >= -one_w) && (wx <= one_w) && (wy >= -one_w) && (wy <= one_w);
    end

    // distance check
    logic [PW-1:0] dl2_full;
    logic [DL-1:0] dl2, one_sq;
    logic          dl_ok;
    assign dl2_full = acc_reg + prod_reg;
    assign dl2      = dl2_full[DL-1:0];
    assign one_sq   = DL'(1) << (2 * F);
    assign dl_ok    = (dl2 != '0) && (dl2 <= one_sq);

    logic [N-1:0] abs_x, abs_y, one_n, one_minus_d;
    assign abs_x       = dx_reg[WW-1] ? N'(-dx_reg) : N'(dx_reg);
    assign abs_y       = dy_reg[WW-1] ? N'(-dy_reg) : N'(dy_reg);
    assign one_n       = N'(1) << F;
    assign one_minus_d = one_n - d_reg;

    // shared iterative root/divide unit
    iu_cmd_t      iu_cmd;
    logic         iu_done;
    logic [N-1:0] iu_res, iu_num;
    always_comb begin
        iu_cmd.start   = (state_reg == S_CHK && dl_ok) || (state_reg == S_MAG)
                      || (state_reg == S_ADDX);
        iu_cmd.is_sqrt = (state_reg == S_CHK);
        iu_num         = (state_reg == S_ADDX) ? abs_y : abs_x;
    end

    sdpfa_iter_unit #(.FRAC(F)) u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (iu_cmd),
        .rad     (dl2),
        .num     (iu_num),
        .den     (d_reg),
        .done    (iu_done),
        .res     (iu_res)
    );

    // shared multiplier, registered product
    logic signed [32:0]   mul_a;
    logic signed [MB-1:0] mul_b;
    logic                 mul_en;
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (state_reg)
            S_SQX: begin
                mul_a = 33'($signed(dx_reg[F+1:0]));
                mul_b = MB'($signed(dx_reg[F+1:0]));
            end
            S_SQY: begin
                mul_a = 33'($signed(dy_reg[F+1:0]));
                mul_b = MB'($signed(dy_reg[F+1:0]));
            end
            S_MAG: begin
                mul_a = 33'(stiff_reg);
                mul_b = MB'(one_minus_d);
            end
            S_MULX, S_MULY: begin
                mul_a = 33'(mag_reg);
                mul_b = MB'(iu_res);
            end
            S_T1: begin
                mul_a = 33'(sum_y_reg);
                mul_b = MB'(rx_reg);
            end
            S_T2: begin
                mul_a = 33'(sum_x_reg);
                mul_b = MB'(ry_reg);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // force component with sign of the separation
    logic [23:0]        f_mag;
    logic signed [32:0] comp_x, comp_y;
    assign f_mag  = prod_reg[F+23:F];
    assign comp_x = dx_reg[WW-1] ? -33'(f_mag) : 33'(f_mag);
    assign comp_y = dy_reg[WW-1] ? -33'(f_mag) : 33'(f_mag);

    // torque: truncate toward zero, saturate to 40 bits
    logic [PW-1:0]      t_abs, t_sh;
    logic signed [39:0] tq;
    always_comb begin
        t_abs = acc_reg[PW-1] ? PW'(-acc_reg) : PW'(acc_reg);
        t_sh  = t_abs >> F;
        if (!acc_reg[PW-1]) begin
            tq = (t_sh > PW'(40'h7F_FFFF_FFFF)) ? 40'sh7F_FFFF_FFFF : 40'(t_sh);
        end else begin
            tq = (t_sh > PW'(40'h80_0000_0000)) ? 40'sh80_0000_0000 : -40'(t_sh);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_acc) state_next = S_WRAP;
            S_WRAP: state_next = near ? S_SQX : S_LAST;
            S_SQX:  state_next = S_SQY;
            S_SQY:  state_next = S_CHK;
            S_CHK:  state_next = dl_ok ? S_SQRT : S_LAST;
            S_SQRT: if (iu_done) state_next = S_MAG;
            S_MAG:  state_next = S_DIVX;
            S_DIVX: if (iu_done) state_next = S_MULX;
            S_MULX: state_next = S_ADDX;
            S_ADDX: state_next = S_DIVY;
            S_DIVY: if (iu_done) state_next = S_MULY;
            S_MULY: state_next = S_ADDY;
            S_ADDY: state_next = S_LAST;
            S_LAST: state_next = last_reg ? S_T1 : S_IDLE;
            S_T1:   state_next = S_T2;
            S_T2:   state_next = S_T3;
            S_T3:   state_next = S_T4;
            S_T4:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            box_reg    <= BOX_RESET;
            stiff_reg  <= STIFF_RESET;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_BOX_SIZE:  box_reg   <= cfg_data[8:0];
                    CFG_STIFFNESS: stiff_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (s_acc && s_tuser) begin
                sum_x_reg <= '0;
                sum_y_reg <= '0;
            end
            if (state_reg == S_ADDX) sum_x_reg <= sat32(33'(sum_x_reg) + comp_x);
            if (state_reg == S_ADDY) sum_y_reg <= sat32(33'(sum_y_reg) + comp_y);
            if (state_reg == S_T4 && out_free) begin
                mvalid_reg <= 1'b1;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end

        if (s_acc) begin
            sx_reg   <= s_tdata[23:0];
            sy_reg   <= s_tdata[47:24];
            ox_reg   <= s_tdata[71:48];
            oy_reg   <= s_tdata[95:72];
            rx_reg   <= 25'($signed(s_tdata[23:0])) - 25'($signed(s_tdata[119:96]));
            ry_reg   <= 25'($signed(s_tdata[47:24])) - 25'($signed(s_tdata[143:120]));
            last_reg <= s_tlast;
        end
        if (state_reg == S_WRAP) begin
            dx_reg <= wx;
            dy_reg <= wy;
        end
        if (mul_en) prod_reg <= PW'(mul_a) * PW'(mul_b);
        if (state_reg == S_SQY || state_reg == S_T2) acc_reg <= prod_reg;
        if (state_reg == S_T3) acc_reg <= acc_reg - prod_reg;
        if (state_reg == S_SQRT && iu_done) d_reg <= iu_res;
        if (state_reg == S_DIVX && iu_done) mag_reg <= prod_reg[F+23:F];
        if (state_reg == S_T4 && out_free) begin
            mdata_reg <= {tq, sum_y_reg, sum_x_reg};
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    `ASSERT_NOW(a_iu_done_state, iu_done,
        state_reg == S_SQRT || state_reg == S_DIVX || state_reg == S_DIVY)
    `ASSERT_NEXT(a_accept_wrap, s_acc, state_reg == S_WRAP)
    `ASSERT_NEXT(a_result_held, state_reg == S_T4 && mvalid_reg && !m_tready,
        state_reg == S_T4 && mvalid_reg)

endmodule

FILE: test/sdpfa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpfa_checker
// Watches the pair and result streams of the soft-disk force accumulator,
// predicts each result from the accepted pairs and the register writes, and
// compares the results field by field in order.
// ----------------------------------------------------------------------------
module sdpfa_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [sdpfa_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [sdpfa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [sdpfa_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,
    input  logic                                s_tlast,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [sdpfa_pkg::M_DATA_W-1:0]      m_tdata,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  results_seen
);
    import sdpfa_pkg::*;

    localparam int FB = POS_FRAC_BITS_DEF;

    typedef struct packed {
        logic signed [39:0] torque_out;
        logic signed [31:0] force_y;
        logic signed [31:0] force_x;
    } force_result_t;

    force_result_t expected_forces[$];

    logic [8:0]  box_reg;
    logic [23:0] stiff_reg;
    longint      acc_fx;
    longint      acc_fy;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint min_image(input longint d, input longint len);
        longint half;
        half = len / 2;
        if (d > half) return d - len;
        if (d < -half) return d + len;
        return d;
    endfunction

    function automatic longint clamp(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic longint axis_force(input longint c, input longint unsigned d,
                                          input longint unsigned mag);
        longint unsigned u;
        longint unsigned f;
        u = ((c < 0 ? -c : c) << FB) / d;
        f = (mag * u) >> FB;
        return c < 0 ? -longint'(f) : longint'(f);
    endfunction

    // add one pair to the sums; return 1 with the result on a last pair
    function automatic bit add_pair(input logic [S_DATA_W-1:0] data, input logic first,
                                    input logic last, output force_result_t res);
        longint sx, sy, ox, oy, cx, cy, len, dx, dy, rx, ry, t, tq;
        longint unsigned b, dl2, one, d, mag;
        sx = longint'($signed(data[23:0]));
        sy = longint'($signed(data[47:24]));
        ox = longint'($signed(data[71:48]));
        oy = longint'($signed(data[95:72]));
        cx = longint'($signed(data[119:96]));
        cy = longint'($signed(data[143:120]));
        one = 64'h1 << FB;
        b = box_reg;
        if (b < 2) b = 2;
        if (b > 256) b = 256;
        len = longint'(b << FB);
        if (first) begin
            acc_fx = 0;
            acc_fy = 0;
        end
        dx = min_image(sx - ox, len);
        dy = min_image(sy - oy, len);
        dl2 = longint'(dx * dx) + longint'(dy * dy);
        if (dl2 != 0 && dl2 <= one * one) begin
            d = int_sqrt(dl2);
            mag = (longint'(stiff_reg) * (one - d)) >> FB;
            acc_fx = clamp(acc_fx + axis_force(dx, d, mag), 32);
            acc_fy = clamp(acc_fy + axis_force(dy, d, mag), 32);
        end
        if (!last) return 0;
        rx = sx - cx;
        ry = sy - cy;
        t = rx * acc_fy - ry * acc_fx;
        tq = (t < 0) ? -((-t) >>> FB) : (t >>> FB);
        tq = clamp(tq, 40);
        res.force_x = acc_fx[31:0];
        res.force_y = acc_fy[31:0];
        res.torque_out = tq[39:0];
        return 1;
    endfunction

    always_ff @(posedge aclk) begin
        force_result_t res;
        force_result_t got;
        if (!aresetn) begin
            box_reg <= BOX_RESET;
            stiff_reg <= STIFF_RESET;
            acc_fx = 0;
            acc_fy = 0;
            expected_forces.delete();
            fail_count <= 0;
            results_seen <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_idx == CFG_BOX_SIZE) box_reg <= cfg_data[8:0];
                else if (cfg_idx == CFG_STIFFNESS) stiff_reg <= cfg_data;
            end
            if (s_tvalid && s_tready) begin
                if (add_pair(s_tdata, s_tuser, s_tlast, res)) expected_forces.push_back(res);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                results_seen <= results_seen + 1;
                if (expected_forces.size() == 0) begin
                    $error("unexpected result: force_x %0d force_y %0d torque_out %0d",
                           got.force_x, got.force_y, got.torque_out);
                    fail_count <= fail_count + 1;
                end else begin
                    res = expected_forces.pop_front();
                    if (got.force_x !== res.force_x)
                        $error("force_x expected %0d actual %0d", res.force_x, got.force_x);
                    if (got.force_y !== res.force_y)
                        $error("force_y expected %0d actual %0d", res.force_y, got.force_y);
                    if (got.torque_out !== res.torque_out)
                        $error("torque_out expected %0d actual %0d",
                               res.torque_out, got.torque_out);
                    if (got !== res) fail_count <= fail_count + 1;
                end
            end
        end
    end

    assign pending = expected_forces.size();

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the soft-disk pair force accumulator: directed corner pairs,
// a saturating run and random runs of pairs over several box and stiffness
// settings, with random gaps and output stalls; the checker does the scoring.
// ----------------------------------------------------------------------------
module tb_top;
    import sdpfa_pkg::*;

    localparam int ONE = 1 << POS_FRAC_BITS_DEF;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 80;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;    // self_x, self_y, other_x, other_y, center_x, center_y
    logic                   s_tuser;    // first_pair
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;    // force_x, force_y, torque_out
    int                     fail_count;
    int                     pending;
    int                     results_seen;
    bit                     idling_on;
    int                     quiet_cycles;
    int                     pairs_sent;
    logic [8:0]             cur_box;

    soft_disk_pair_force_accumulator uut (.*);

    sdpfa_checker checker_i (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // result side: random stall bursts
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready <= 0;
                stall_left--;
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 0;
                stall_left = $urandom_range(0, 2);
            end else begin
                m_tready <= 1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT) begin
            $display("soft_disk_pair_force_accumulator test failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
        @(negedge aclk);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= val;
        if (idx == CFG_BOX_SIZE) cur_box = val[8:0];
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    // let every result drain, then give a trailing no-result pair time to finish
    task automatic settle();
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_pair(input int sx, input int sy, input int ox, input int oy,
                             input int cx, input int cy, input bit first, input bit last);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1;
        s_tdata <= {cy[23:0], cx[23:0], oy[23:0], ox[23:0], sy[23:0], sx[23:0]};
        s_tuser <= first;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pairs_sent++;
        @(negedge aclk);
        s_tvalid <= 0;
    endtask

    function automatic int rand_pos();
        return int'($urandom);
    endfunction

    // neighbour of a random kind: close, across the box edge, or anywhere
    task automatic send_random_pair(input bit first, input bit last);
        int sx, sy, ox, oy, cx, cy, boxlen, pick;
        boxlen = int'(cur_box) * ONE;
        sx = rand_pos();
        sy = rand_pos();
        pick = $urandom_range(0, 9);
        ox = sx + $urandom_range(0, 140000) - 70000;
        oy = sy + $urandom_range(0, 140000) - 70000;
        if (pick >= 6 && pick < 8) begin
            ox += ($urandom_range(0, 1) ? boxlen : -boxlen);
            if ($urandom_range(0, 1)) oy += ($urandom_range(0, 1) ? boxlen : -boxlen);
        end else if (pick >= 8) begin
            ox = rand_pos();
            oy = rand_pos();
        end
        if ($urandom_range(0, 1)) begin
            cx = rand_pos();
            cy = rand_pos();
        end else begin
            cx = sx + $urandom_range(0, 400000) - 200000;
            cy = sy + $urandom_range(0, 400000) - 200000;
        end
        send_pair(sx, sy, ox, oy, cx, cy, first, last);
    endtask

    task automatic random_runs(input int n_pairs);
        int left, run_len;
        left = n_pairs;
        while (left > 0) begin
            run_len = $urandom_range(1, 6);
            if (run_len > left) run_len = left;
            for (int k = 0; k < run_len; k++) begin
                send_random_pair(k == 0 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0),
                                 k == run_len - 1 ? ($urandom_range(0, 9) != 0)
                                                  : ($urandom_range(0, 19) == 0));
            end
            left -= run_len;
        end
    endtask

    initial begin
        aresetn = 0;
        cfg_we = 0;
        cfg_idx = CFG_BOX_SIZE;
        cfg_data = '0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = 0;
        s_tlast = 0;
        idling_on = 1;
        quiet_cycles = 0;
        pairs_sent = 0;
        cur_box = BOX_RESET;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed pairs at reset settings
        send_pair(32'h7FFFFF, 32'h7FFFFF, -32'h800000, -32'h800000,
                  -32'h800000, 32'h7FFFFF, 1, 1);                       // far apart
        send_pair(100, 200, 100, 200, 0, 0, 1, 1);                     // same point
        send_pair(ONE, 0, 0, 0, 0, 0, 1, 1);                           // exactly one unit
        send_pair(0, 0, ONE / 2, ONE / 3, 5 * ONE, -3 * ONE, 1, 0);     // in range
        send_pair(0, 0, -ONE / 4, 0, 5 * ONE, -3 * ONE, 0, 0);         // keep summing
        send_pair(ONE / 8, 0, 0, ONE / 5, -32'h800000, 32'h7FFFFF, 0, 1);
        send_pair(0, 0, ONE / 2, 0, 0, ONE, 0, 1);                     // continue after result
        send_pair(31 * ONE + ONE / 2, 0, -32 * ONE, 0, 0, 0, 1, 1);    // wraps across edge
        send_pair(95 * ONE, 0, 0, ONE / 4, 0, 0, 1, 1);                // beyond one wrap
        send_pair(-32'h800000, 32'h7FFFFF, -32'h800000, 32'h7FFFFF - 1,
                  32'h7FFFFF, -32'h800000, 1, 1);
        settle();

        // tiny box, no stiffness
        write_reg(CFG_BOX_SIZE, 24'd2);
        write_reg(CFG_STIFFNESS, 24'd0);
        random_runs(50);
        settle();

        // largest box, full stiffness: push both sums into saturation
        write_reg(CFG_BOX_SIZE, 24'd256);
        write_reg(CFG_STIFFNESS, 24'hFFFFFF);
        for (int k = 0; k < 140; k++)
            send_pair(0, 0, -1, 1, -32'h800000, -32'h800000, k == 0, k == 139);
        random_runs(70);
        settle();

        // box below and above the legal range
        write_reg(CFG_BOX_SIZE, 24'd0);
        write_reg(CFG_STIFFNESS, 24'($urandom));
        random_runs(50);
        settle();
        write_reg(CFG_BOX_SIZE, 24'h1FF);
        random_runs(50);
        settle();
        write_reg(CFG_BOX_SIZE, 24'd1);
        write_reg(CFG_STIFFNESS, 24'($urandom_range(0, 4 * ONE)));
        random_runs(40);
        settle();

        write_reg(CFG_BOX_SIZE, 24'($urandom_range(2, 256)));
        write_reg(CFG_STIFFNESS, 24'($urandom));
        random_runs(100);
        idling_on = 0;
        random_runs(40);

        settle();
        $display("Covered %0d pairs and %0d results over boxes 0..511 and stiffness 0..max,",
                 pairs_sent, results_seen);
        $display("including wrapped, far, coincident and saturating pairs.");
        if (fail_count == 0) begin
            $display("soft_disk_pair_force_accumulator test passed");
        end else begin
            $display("soft_disk_pair_force_accumulator test failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/sdpfa_pkg.sv
design/sdpfa_iter_unit.sv
design/soft_disk_pair_force_accumulator.sv
test/sdpfa_checker.sv
test/tb_top.sv
